/* rtl/cv2_pkg.sv */
package cv2_pkg;

  // Input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_COEF  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KSIZE  = 2'd2;

  // Default sizing
  localparam int DEF_MAX_K = 7;
  localparam int DEF_MAX_W = 1024;
  localparam int DEF_MAX_H = 1024;

  // Column field wide enough for any padded line the parameters allow
  localparam int COL_W = 14;

  // Queue depths (powers of two)
  localparam int IQ_DEPTH = 4;
  localparam int OQ_DEPTH = 8;

  localparam int PIX_W = 16;
  localparam int RES_W = 24;
  localparam int POS_W = 10;
  localparam int PROD_W = 2 * PIX_W;
  localparam int FRAC_SHIFT = 14;

  // One classified item handed from the front to the back
  typedef struct packed {
    logic                    is_pix;
    logic signed [PIX_W-1:0] data;
    logic [COL_W-1:0]        col;
    logic [5:0]              cidx;
    logic                    emit;
    logic                    last;
    logic [POS_W-1:0]        oy;
    logic [POS_W-1:0]        ox;
  } cv2_item_t;

  // One finished result beat
  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } cv2_res_t;

endpackage

/* rtl/conv2d_sliding_window.sv */
// KxK 2-D correlation over a pre-padded raster stream ("same" padding, p = K/2).
// Pixels (cmd 0) and coefficient loads (cmd 1) enter through a queue-style port at
// one beat per clock while not full; each window position inside the W x H output
// yields one result (signed 24 bits, floored by the Q2.14 coefficient scale) with
// its row, column and an end-of-frame flag. Sustained rate is one item per clock
// while the output queue has room, set by the line store read when an item enters
// the datapath and written back in the next cycle at its own column. Each item
// passes the input queue, the line store read, the window update, the multiplier
// row and the row sums; the final row add feeds the output queue.
// Results wait in an eight-entry output queue, so a stalled consumer fills it
// before the input side reports full. Register writes (width, height, kernel
// size) restart the frame and must be made while the block is idle. The line
// store has no clearing pass and needs no warm-up after reset.
module conv2d_sliding_window #(
  parameter int MAX_K = cv2_pkg::DEF_MAX_K,
  parameter int MAX_W = cv2_pkg::DEF_MAX_W,
  parameter int MAX_H = cv2_pkg::DEF_MAX_H
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic signed [15:0] pixel,
  input  logic [5:0]         coef_index,
  input  logic signed [15:0] coef_value,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] result,
  output logic [9:0]         out_row,
  output logic [9:0]         out_col,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);
  import cv2_pkg::*;

  localparam int OLW = $clog2(OQ_DEPTH+1);
  localparam int ILW = $clog2(IQ_DEPTH+1);

  cv2_item_t      f_item;
  cv2_item_t      q_head;
  logic           f_wr;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic [ILW-1:0] q_level;
  logic [2:0]     ksize;
  logic           res_push;
  cv2_res_t       res_in;
  cv2_res_t       res_out;
  logic           o_full;
  logic [OLW-1:0] o_level;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign result    = res_out.result;
  assign out_row   = res_out.row;
  assign out_col   = res_out.col;
  assign last      = res_out.last;

  cv2_front #(.MAX_K(MAX_K), .MAX_W(MAX_W), .MAX_H(MAX_H)) u_front (
    .clk, .rst, .push, .q_full, .cmd, .pixel, .coef_index, .coef_value,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .q_wr(f_wr), .q_item(f_item), .ksize
  );

  cv2_fifo #(.WIDTH($bits(cv2_item_t)), .DEPTH(IQ_DEPTH)) u_iq (
    .clk, .rst, .wr(f_wr), .wdata(f_item), .rd(q_pop), .rdata(q_head),
    .full(q_full), .empty(q_empty), .level(q_level)
  );

  cv2_back #(.MAX_K(MAX_K), .MAX_W(MAX_W)) u_back (
    .clk, .rst, .q_empty, .q_item(q_head), .q_pop, .ksize,
    .out_level(o_level), .res_push, .res(res_in)
  );

  cv2_fifo #(.WIDTH($bits(cv2_res_t)), .DEPTH(OQ_DEPTH)) u_oq (
    .clk, .rst, .wr(res_push), .wdata(res_in), .rd(pop), .rdata(res_out),
    .full(o_full), .empty(empty), .level(o_level)
  );

  // Credit scheme must keep the result queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !o_full)
    else $error("result queue overflow");

  // Datapath never takes from an empty input queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_level != '0))
    else $error("input queue underflow");

  // A last beat is never pushed again without a fresh item admitted behind it
  a_last_bound: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_in.last) |=> !(res_push && res_in.last && $stable(res_in.row)
      && $stable(res_in.col) && $past(!q_pop) && $past(!q_pop, 2) && $past(!q_pop, 3)
      && $past(!q_pop, 4) && $past(!q_pop, 5)))
    else $error("repeated last beat");
endmodule

/* rtl/cv2_fifo.sv */
module cv2_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       rd,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [LW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == LW'(DEPTH));
  assign empty = (count == '0);
  assign level = count;
  assign rdata = store[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  // Hold payload entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + LW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - LW'(1);
      end
    end
  end
endmodule

/* rtl/cv2_front.sv */
module cv2_front #(
  parameter int MAX_K = 7,
  parameter int MAX_W = 1024,
  parameter int MAX_H = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic                     q_full,
  input  logic                     cmd,
  input  logic signed [15:0]       pixel,
  input  logic [5:0]               coef_index,
  input  logic signed [15:0]       coef_value,
  input  logic                     cfg_valid,
  input  logic [1:0]               cfg_index,
  input  logic [10:0]              cfg_data,
  output logic                     q_wr,
  output cv2_pkg::cv2_item_t       q_item,
  output logic [2:0]               ksize
);
  import cv2_pkg::*;

  localparam int WW = $clog2(MAX_W+1);
  localparam int HW = $clog2(MAX_H+1);
  localparam int CW = $clog2(MAX_W + 2*(MAX_K/2));
  localparam int RW = $clog2(MAX_H + 2*(MAX_K/2));
  localparam int W_RST = (MAX_W < 1024) ? MAX_W : 1024;
  localparam int H_RST = (MAX_H < 1024) ? MAX_H : 1024;
  localparam int K_RST = (MAX_K < 3) ? MAX_K : 3;
  localparam int K_TOP = (MAX_K < 7) ? MAX_K : 7;

  logic [WW-1:0] img_w;
  logic [HW-1:0] img_h;
  logic [2:0]    kern;
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col_next;
  logic [RW-1:0] in_row_next;
  logic [15:0]   c16, r16, k16, w16, h16, pw16, ph16, oy16, ox16;
  logic          emit;
  logic [2:0]    kv;

  assign ksize = kern;
  assign q_wr  = push && !q_full;
  assign kv    = cfg_data[2:0];

  // Work out the window position of this pixel
  always_comb begin
    c16  = 16'(in_col);
    r16  = 16'(in_row);
    k16  = 16'(kern);
    w16  = 16'(img_w);
    h16  = 16'(img_h);
    pw16 = w16 + 16'(kern[2:1]) * 16'd2;
    ph16 = h16 + 16'(kern[2:1]) * 16'd2;
    oy16 = r16 - (k16 - 16'd1);
    ox16 = c16 - (k16 - 16'd1);
    emit = (r16 >= k16 - 16'd1) && (c16 >= k16 - 16'd1) && (oy16 < h16) && (ox16 < w16);
    if (c16 + 16'd1 >= pw16) begin
      in_col_next = '0;
      in_row_next = (r16 + 16'd1 >= ph16) ? '0 : in_row + RW'(1);
    end else begin
      in_col_next = in_col + CW'(1);
      in_row_next = in_row;
    end
  end

  // Classify the beat
  always_comb begin
    q_item.is_pix = (cmd == CMD_PIXEL);
    q_item.data   = (cmd == CMD_PIXEL) ? pixel : coef_value;
    q_item.col    = COL_W'(in_col);
    q_item.cidx   = coef_index;
    q_item.emit   = (cmd == CMD_PIXEL) && emit;
    q_item.last   = (oy16 == h16 - 16'd1) && (ox16 == w16 - 16'd1);
    q_item.oy     = oy16[POS_W-1:0];
    q_item.ox     = ox16[POS_W-1:0];
  end

  // Hold configuration and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w  <= WW'(W_RST);
      img_h  <= HW'(H_RST);
      kern   <= 3'(K_RST);
      in_col <= '0;
      in_row <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH: begin
          if (cfg_data == '0) img_w <= WW'(1);
          else if (32'(cfg_data) > 32'(MAX_W)) img_w <= WW'(MAX_W);
          else img_w <= WW'(cfg_data);
          in_col <= '0;
          in_row <= '0;
        end
        CFG_HEIGHT: begin
          if (cfg_data == '0) img_h <= HW'(1);
          else if (32'(cfg_data) > 32'(MAX_H)) img_h <= HW'(MAX_H);
          else img_h <= HW'(cfg_data);
          in_col <= '0;
          in_row <= '0;
        end
        CFG_KSIZE: begin
          if (kv == '0) kern <= 3'd1;
          else if (32'(kv) > 32'(K_TOP)) kern <= 3'(K_TOP);
          else kern <= kv;
          in_col <= '0;
          in_row <= '0;
        end
        default: begin
        end
      endcase
    end else if (q_wr && cmd == CMD_PIXEL) begin
      in_col <= in_col_next;
      in_row <= in_row_next;
    end
  end
endmodule

/* rtl/cv2_back.sv */
module cv2_back #(
  parameter int MAX_K = 7,
  parameter int MAX_W = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  input  cv2_pkg::cv2_item_t                 q_item,
  output logic                               q_pop,
  input  logic [2:0]                         ksize,
  input  logic [$clog2(cv2_pkg::OQ_DEPTH+1)-1:0] out_level,
  output logic                               res_push,
  output cv2_pkg::cv2_res_t                  res
);
  import cv2_pkg::*;

  localparam int NL = (MAX_K > 1) ? MAX_K - 1 : 1;
  localparam int LINE_LEN = MAX_W + 2*(MAX_K/2);
  localparam int AW = $clog2(LINE_LEN);
  localparam int NCOEF = MAX_K * MAX_K;
  localparam int RSW = PROD_W + $clog2(MAX_K) + 1;
  localparam int TW = PROD_W + $clog2(NCOEF) + 1;

  logic [NL*PIX_W-1:0]        line_mem [LINE_LEN];
  logic [NL*PIX_W-1:0]        line_rd;
  logic [NL*PIX_W-1:0]        line_wr;
  logic signed [PIX_W-1:0]    colv [MAX_K];
  logic signed [PIX_W-1:0]    win  [MAX_K][MAX_K];
  logic signed [PIX_W-1:0]    coef [NCOEF];
  logic signed [PROD_W-1:0]   prod [MAX_K][MAX_K];
  logic signed [RSW-1:0]      rsum [MAX_K];
  logic signed [TW-1:0]       total;
  logic                       v1, v2, v3, v4;
  cv2_item_t                  it1, it2, it3, it4;
  logic [4:0]                 pending;
  logic                       px1;

  assign px1 = v1 && it1.is_pix;

  // Admit an item only when the result queue has room for all in flight
  always_comb begin
    pending = 5'(out_level) + 5'(v1 && it1.emit) + 5'(v2 && it2.emit)
            + 5'(v3 && it3.emit) + 5'(v4 && it4.emit);
    q_pop = !q_empty && (pending < 5'(OQ_DEPTH));
  end

  // Advance the pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= q_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    it1 <= q_item;
    it2 <= it1;
    it3 <= it2;
    it4 <= it3;
  end

  // Line store: read on admit, write back the shifted column once the item is registered in it1
  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_rd <= line_mem[q_item.col[AW-1:0]];
    end
    if (px1) begin
      line_mem[it1.col[AW-1:0]] <= line_wr;
    end
  end

  // Shift the lines up at this column
  for (genvar l = 0; l < NL; l++) begin : g_line
    always_comb begin
      if (l + 2 < int'(ksize) && l + 1 < NL) begin
        line_wr[l*PIX_W +: PIX_W] = line_rd[((l+1 < NL) ? l+1 : l)*PIX_W +: PIX_W];
      end else if (l + 2 == int'(ksize)) begin
        line_wr[l*PIX_W +: PIX_W] = it1.data;
      end else begin
        line_wr[l*PIX_W +: PIX_W] = line_rd[l*PIX_W +: PIX_W];
      end
    end
  end

  // Build the new window column
  for (genvar ky = 0; ky < MAX_K; ky++) begin : g_col
    if (ky < MAX_K - 1) begin : g_mid
      assign colv[ky] = (ky == int'(ksize) - 1) ? it1.data
                                                 : signed'(line_rd[ky*PIX_W +: PIX_W]);
    end else begin : g_top
      assign colv[ky] = it1.data;
    end
  end

  // Shift the window left and insert the column
  for (genvar ky = 0; ky < MAX_K; ky++) begin : g_wy
    for (genvar kx = 0; kx < MAX_K; kx++) begin : g_wx
      always_ff @(posedge clk) begin
        if (rst) begin
          win[ky][kx] <= '0;
        end else if (px1 && ky < int'(ksize)) begin
          if (kx + 1 < int'(ksize)) begin
            win[ky][kx] <= win[ky][(kx+1 < MAX_K) ? kx+1 : kx];
          end else if (kx + 1 == int'(ksize)) begin
            win[ky][kx] <= colv[ky];
          end
        end
      end
    end
  end

  // Load coefficients in order with the pixels around them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef[i] <= '0;
      end
    end else if (v2 && !it2.is_pix && 32'(it2.cidx) < 32'(NCOEF)) begin
      coef[it2.cidx[$clog2(NCOEF+1)-1:0]] <= it2.data;
    end
  end

  // Multiply each tap by its coefficient for the current kernel size
  for (genvar ky = 0; ky < MAX_K; ky++) begin : g_py
    for (genvar kx = 0; kx < MAX_K; kx++) begin : g_px
      logic signed [PIX_W-1:0] csel;
      always_comb begin
        csel = '0;
        for (int j = 1; j <= MAX_K; j++) begin
          if (int'(ksize) == j && ky < j && kx < j) begin
            csel = coef[ky*j + kx];
          end
        end
      end
      always_ff @(posedge clk) begin
        prod[ky][kx] <= win[ky][kx] * csel;
      end
    end
  end

  function automatic logic signed [RSW-1:0] row_add(input int ky);
    logic signed [RSW-1:0] acc;
    acc = '0;
    for (int kx = 0; kx < MAX_K; kx++) begin
      acc = acc + RSW'(prod[ky][kx]);
    end
    return acc;
  endfunction

  // Sum each kernel row
  always_ff @(posedge clk) begin
    for (int ky = 0; ky < MAX_K; ky++) begin
      rsum[ky] <= row_add(ky);
    end
  end

  // Add the rows, floor by the coefficient fraction
  always_comb begin
    total = '0;
    for (int ky = 0; ky < MAX_K; ky++) begin
      total = total + TW'(rsum[ky]);
    end
    res.result = RES_W'(total >>> FRAC_SHIFT);
    res.row    = it4.oy;
    res.col    = it4.ox;
    res.last   = it4.last;
    res_push   = v4 && it4.emit;
  end
endmodule
